// ===== design/hmfd_pkg.sv =====
package hmfd_pkg;

    localparam int BUFFER_DEPTH_DEF = 32768;
    localparam int CHANNELS_DEF     = 2;
    localparam int SAMPLE_BITS_DEF  = 24;
    localparam int FRAC_BITS_DEF    = 16;

    localparam int DELAY_W   = 31;
    localparam int GAIN_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int LINES     = 4;

    localparam logic [CFG_IDX_W-1:0] REG_DELAY_ONE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_TWO   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_THREE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FB_GAIN     = 2'd3;

    localparam logic [DELAY_W-1:0] DELAY_RESET = 31'd65536;

    localparam logic [1:0] STEP_D2 = 2'd0;
    localparam logic [1:0] STEP_D1 = 2'd1;
    localparam logic [1:0] STEP_D0 = 2'd2;

    typedef struct packed {
        logic       rd_en;
        logic       cap_en;
        logic [1:0] cap_idx;
        logic       load;
        logic       step_en;
        logic [1:0] step_sel;
    } hmfd_ctrl_t;

endpackage

// ===== design/hmfd_line.sv =====
module hmfd_line
    import hmfd_pkg::*;
#(
    parameter int ADDR_W      = 16,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    parameter int T_W         = SAMPLE_BITS + 5
)
(
    input  logic                          clk,
    input  hmfd_ctrl_t                    ctrl,
    input  logic [ADDR_W-1:0]             rd_addr,
    input  logic                          wr_en,
    input  logic [ADDR_W-1:0]             wr_addr,
    input  logic signed [SAMPLE_BITS-1:0] wr_data,
    input  logic [FRAC_BITS-1:0]          frac,
    output logic signed [T_W-1:0]         result
);

    localparam int P_W = T_W + FRAC_BITS + 1;

    logic signed [SAMPLE_BITS-1:0] mem [2**ADDR_W];
    logic signed [SAMPLE_BITS-1:0] rd_data_reg;
    logic signed [SAMPLE_BITS-1:0] tap_reg [4];
    logic signed [T_W-1:0]         t_reg;
    logic signed [T_W-1:0]         t_next;
    logic signed [T_W-1:0]         tp, ta, tb, tc;
    logic signed [T_W-1:0]         d0, d1, d2, d3, d_sel;
    logic signed [P_W-1:0]         prod;
    logic signed [P_W-1:0]         rnd;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctrl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.cap_en)
        begin
            tap_reg[ctrl.cap_idx] <= rd_data_reg;
        end
        t_reg <= t_next;
    end

    always_comb
    begin
        tp = T_W'(tap_reg[0]);
        ta = T_W'(tap_reg[1]);
        tb = T_W'(tap_reg[2]);
        tc = T_W'(tap_reg[3]);
        d0 = ta <<< 1;
        d1 = tb - tp;
        d2 = (tp <<< 1) - (ta <<< 2) - ta + (tb <<< 2) - tc;
        d3 = (tc - tp) + ((ta - tb) <<< 1) + (ta - tb);
        unique case (ctrl.step_sel)
            STEP_D2: d_sel = d2;
            STEP_D1: d_sel = d1;
            default: d_sel = d0;
        endcase
        prod = P_W'(t_reg) * $signed({1'b0, frac});
        rnd  = (prod + (P_W'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        priority if (ctrl.load)
        begin
            t_next = d3;
        end
        else if (ctrl.step_en)
        begin
            t_next = rnd[T_W-1:0] + d_sel;
        end
        else
        begin
            t_next = t_reg;
        end
    end

    assign result = t_reg;

endmodule

// ===== design/hermite_multitap_feedback_delay_core.sv =====
// Multi-tap feedback delay with Hermite fractional interpolation.
// Input words carry a channel and three samples over in_valid / in_stall;
// a word is taken when in_valid is high and in_stall low. Each input word
// gives one output word (out_channel, out_sample) over out_valid /
// out_stall. Configuration is written through cfg_wr_en / cfg_index /
// cfg_data; the user must write it only while the block is idle, as the
// block itself has no guard for this.
// The block works on one word at a time and spends an idle state before
// taking the next. Each word goes through four reads per line from its
// memory, three Horner steps, sum, feedback gain and write-back.
// After reset the four line memories are swept to zero, one address per
// cycle over all of their addresses (65536 by default); in_stall stays
// high meanwhile.
// When the receiver stalls, the result is held in the output register and
// the next input word is still taken; its result waits until the register
// is free.
module hermite_multitap_feedback_delay_core
    import hmfd_pkg::*;
#(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF,
    parameter int CHANNELS     = CHANNELS_DEF,
    parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
    parameter int FRAC_BITS    = FRAC_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          channel,
    input  logic signed [SAMPLE_BITS-1:0] sample_one,
    input  logic signed [SAMPLE_BITS-1:0] sample_two,
    input  logic signed [SAMPLE_BITS-1:0] sample_three,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          out_channel,
    output logic signed [SAMPLE_BITS-1:0] out_sample,
    input  logic                          cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [DELAY_W-1:0]            cfg_data
);

    localparam int POS_W  = $clog2(BUFFER_DEPTH);
    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int ADDR_W = CH_W + POS_W;
    localparam int T_W    = SAMPLE_BITS + 5;
    localparam int S_W    = T_W + 2;
    localparam int G_W    = SAMPLE_BITS + GAIN_W + 1;

    typedef enum logic [6:0] {
        ST_CLEAR = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_READ  = 7'b0000100,
        ST_HORN  = 7'b0001000,
        ST_SUM   = 7'b0010000,
        ST_FB    = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic [2:0]        cnt_reg, cnt_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic [POS_W-1:0]  wp_reg [CHANNELS];

    logic [DELAY_W-1:0]       delay_one_reg, delay_two_reg, delay_three_reg;
    logic signed [GAIN_W-1:0] gain_reg;

    logic [CH_W-1:0]               ch_reg;
    logic                          chf_reg;
    logic signed [SAMPLE_BITS-1:0] s1_reg, s2_reg, s3_reg;
    logic signed [SAMPLE_BITS-1:0] y_reg, fb_reg;
    logic                          out_valid_reg;
    logic                          out_channel_reg;
    logic signed [SAMPLE_BITS-1:0] out_sample_reg;

    logic [DELAY_W-1:0]            dly [LINES];
    logic [ADDR_W-1:0]             rd_addr [LINES];
    logic signed [SAMPLE_BITS-1:0] wr_data [LINES];
    logic signed [T_W-1:0]         res [LINES];
    logic [ADDR_W-1:0]             wr_addr;
    logic                          wr_en;
    logic [CH_W-1:0]               ch_in;
    logic [POS_W-1:0]              wp_cur;
    hmfd_ctrl_t                    ctrl;
    logic                          accept, finish;

    logic signed [S_W-1:0]       sum;
    logic signed [S_W-1:0]       half;
    logic signed [G_W-1:0]       gprod;
    logic signed [G_W-1:0]       gsh;
    logic signed [SAMPLE_BITS-1:0] y_sat, fb_sat;

    localparam logic signed [S_W-1:0] SMAX_S = S_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [S_W-1:0] SMIN_S = -SMAX_S - S_W'(1);
    localparam logic signed [G_W-1:0] SMAX_G = G_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [G_W-1:0] SMIN_G = -SMAX_G - G_W'(1);

    assign ch_in  = (CHANNELS > 1) ? CH_W'(channel) : '0;
    assign accept = in_valid && !in_stall;
    assign finish = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);
    assign wp_cur = wp_reg[ch_reg];
    assign in_stall = (state_reg != ST_IDLE);

    assign dly[0] = delay_three_reg;
    assign dly[1] = delay_one_reg;
    assign dly[2] = delay_two_reg;
    assign dly[3] = delay_three_reg;

    always_comb
    begin
        logic [DELAY_W+POS_W-1:0] ext;
        logic [POS_W-1:0]         di;
        for (int i = 0; i < LINES; i++)
        begin
            ext        = {{POS_W{1'b0}}, dly[i]};
            di         = ext[FRAC_BITS +: POS_W];
            rd_addr[i] = {ch_reg, POS_W'(wp_cur - di - POS_W'(cnt_reg))};
        end
    end

    always_comb
    begin
        ctrl          = '0;
        ctrl.rd_en    = (state_reg == ST_READ) && (cnt_reg < 3'd4);
        ctrl.cap_en   = (state_reg == ST_READ) && (cnt_reg != 3'd0);
        ctrl.cap_idx  = 2'(cnt_reg - 3'd1);
        ctrl.load     = (state_reg == ST_HORN) && (cnt_reg == 3'd0);
        ctrl.step_en  = (state_reg == ST_HORN) && (cnt_reg != 3'd0);
        ctrl.step_sel = 2'(cnt_reg - 3'd1);
    end

    always_comb
    begin
        wr_en   = (state_reg == ST_CLEAR) || finish;
        wr_addr = (state_reg == ST_CLEAR) ? clr_reg : {ch_reg, wp_cur};
        if (state_reg == ST_CLEAR)
        begin
            for (int i = 0; i < LINES; i++)
            begin
                wr_data[i] = '0;
            end
        end
        else
        begin
            wr_data[0] = fb_reg;
            wr_data[1] = s1_reg;
            wr_data[2] = s2_reg;
            wr_data[3] = s3_reg;
        end
    end

    for (genvar g = 0; g < LINES; g++)
    begin : g_line
        hmfd_line #(
            .ADDR_W      (ADDR_W),
            .SAMPLE_BITS (SAMPLE_BITS),
            .FRAC_BITS   (FRAC_BITS),
            .T_W         (T_W)
        ) u_line (
            .clk     (clk),
            .ctrl    (ctrl),
            .rd_addr (rd_addr[g]),
            .wr_en   (wr_en),
            .wr_addr (wr_addr),
            .wr_data (wr_data[g]),
            .frac    (dly[g][FRAC_BITS-1:0]),
            .result  (res[g])
        );
    end

    always_comb
    begin
        sum  = S_W'(res[0]) + S_W'(res[1]) + S_W'(res[2]) + S_W'(res[3]);
        half = (sum + S_W'(1)) >>> 1;
        priority if (half > SMAX_S)
        begin
            y_sat = SMAX_S[SAMPLE_BITS-1:0];
        end
        else if (half < SMIN_S)
        begin
            y_sat = SMIN_S[SAMPLE_BITS-1:0];
        end
        else
        begin
            y_sat = half[SAMPLE_BITS-1:0];
        end
        gprod = G_W'(gain_reg) * G_W'(y_reg);
        gsh   = (gprod + (G_W'(1) <<< 14)) >>> 15;
        priority if (gsh > SMAX_G)
        begin
            fb_sat = SMAX_G[SAMPLE_BITS-1:0];
        end
        else if (gsh < SMIN_G)
        begin
            fb_sat = SMIN_G[SAMPLE_BITS-1:0];
        end
        else
        begin
            fb_sat = gsh[SAMPLE_BITS-1:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        clr_next   = clr_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + ADDR_W'(1);
                if (clr_reg == {ADDR_W{1'b1}})
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                cnt_next = '0;
                if (accept)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd4)
                begin
                    cnt_next   = '0;
                    state_next = ST_HORN;
                end
            end
            ST_HORN:
            begin
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd3)
                begin
                    cnt_next   = '0;
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                state_next = ST_FB;
            end
            ST_FB:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (finish)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            cnt_reg         <= '0;
            clr_reg         <= '0;
            out_valid_reg   <= 1'b0;
            delay_one_reg   <= DELAY_RESET;
            delay_two_reg   <= DELAY_RESET;
            delay_three_reg <= DELAY_RESET;
            gain_reg        <= '0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                wp_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            clr_reg   <= clr_next;
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    REG_DELAY_ONE:   delay_one_reg   <= cfg_data;
                    REG_DELAY_TWO:   delay_two_reg   <= cfg_data;
                    REG_DELAY_THREE: delay_three_reg <= cfg_data;
                    REG_FB_GAIN:     gain_reg        <= cfg_data[GAIN_W-1:0];
                    default:         ;
                endcase
            end
            if (finish)
            begin
                out_valid_reg  <= 1'b1;
                wp_reg[ch_reg] <= wp_cur + POS_W'(1);
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ch_reg  <= ch_in;
            chf_reg <= channel;
            s1_reg  <= sample_one;
            s2_reg  <= sample_two;
            s3_reg  <= sample_three;
        end
        if (state_reg == ST_SUM)
        begin
            y_reg <= y_sat;
        end
        if (state_reg == ST_FB)
        begin
            fb_reg <= fb_sat;
        end
        if (finish)
        begin
            out_channel_reg <= chf_reg;
            out_sample_reg  <= y_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_channel = out_channel_reg;
    assign out_sample  = out_sample_reg;

endmodule
